/* rtl/dlrf_pkg.sv */
// ----------------------------------------------------------------------------
// dlrf_pkg
// Shared types, widths and constants of the downmix / resampler / framer.
// ----------------------------------------------------------------------------
package dlrf_pkg;

  localparam int SMP_W     = 16;
  localparam int SUM_W     = 19;
  localparam int CNT_W     = 4;
  localparam int STEP_W    = 28;
  localparam int FRAC_W    = 24;
  localparam int MA_W      = 20;
  localparam int MB_W      = 24;
  localparam int P_W       = 45;
  localparam int RCP_SHIFT = 22;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam int FRAME_SAMPLES_DEF = 960;
  localparam int MAX_CHANNELS_DEF  = 8;

  localparam logic [STEP_W-1:0] STEP_MIN   = 28'd2796203;
  localparam logic [STEP_W-1:0] STEP_MAX   = 28'd134217728;
  localparam logic [STEP_W-1:0] STEP_RESET = 28'd16777216;
  localparam logic [STEP_W-1:0] ONE_Q24    = 28'd16777216;
  localparam logic [CNT_W-1:0]  CHAN_RESET = 4'd1;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_RATE_STEP     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_MUL,
    ST_AVG_DONE,
    ST_INT_MUL,
    ST_INT_OUT,
    ST_DISCARD
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  channel_count;
    logic [STEP_W-1:0] rate_step;
  } cfg_t;

  // ceil(2^22 / n), exact floor division for numerators below 2^19
  function automatic logic [MB_W-1:0] rcp(input logic [CNT_W-1:0] n);
    logic [MB_W-1:0] r;
    case (n)
      4'd1:    r = 24'd4194304;
      4'd2:    r = 24'd2097152;
      4'd3:    r = 24'd1398102;
      4'd4:    r = 24'd1048576;
      4'd5:    r = 24'd838861;
      4'd6:    r = 24'd699051;
      4'd7:    r = 24'd599187;
      4'd8:    r = 24'd524288;
      default: r = 24'd4194304;
    endcase
    return r;
  endfunction

endpackage

/* rtl/dlrf_mul.sv */
// ----------------------------------------------------------------------------
// dlrf_mul
// Shared registered multiplier: signed operand times unsigned operand.
// ----------------------------------------------------------------------------
module dlrf_mul (
  input  logic                         clk,
  input  logic signed [dlrf_pkg::MA_W-1:0] op_a,
  input  logic [dlrf_pkg::MB_W-1:0]    op_b,
  output logic signed [dlrf_pkg::P_W-1:0]  prod_r
);
  import dlrf_pkg::*;

  logic signed [P_W-1:0] prod_nxt;

  assign prod_nxt = P_W'(op_a) * P_W'($signed({1'b0, op_b}));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* rtl/dlrf_regs.sv */
// ----------------------------------------------------------------------------
// dlrf_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module dlrf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dlrf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [dlrf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [dlrf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output dlrf_pkg::cfg_t                cfg
);
  import dlrf_pkg::*;

  logic [CNT_W-1:0]  chan_r, chan_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              wr_en;
  logic              idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    chan_nxt = chan_r;
    step_nxt = step_r;
    if (wr_en) begin
      case (idx)
        REG_CHANNEL_COUNT: chan_nxt = cfg_pwdata[CNT_W-1:0];
        REG_RATE_STEP:     step_nxt = cfg_pwdata[STEP_W-1:0];
        default:           chan_nxt = chan_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= CHAN_RESET;
      step_r <= STEP_RESET;
    end else begin
      chan_r <= chan_nxt;
      step_r <= step_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL_COUNT: cfg_prdata = DATA_W'(chan_r);
      REG_RATE_STEP:     cfg_prdata = DATA_W'(step_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg.channel_count = chan_r;
  assign cfg.rate_step     = step_r;

endmodule

/* rtl/dlrf_ctrl.sv */
// ----------------------------------------------------------------------------
// dlrf_ctrl
// Sequencer and datapath: downmix, interpolation cursor, framing, output reg.
// ----------------------------------------------------------------------------
module dlrf_ctrl #(
  parameter int FRAME_SAMPLES = dlrf_pkg::FRAME_SAMPLES_DEF,
  parameter int MAX_CHANNELS  = dlrf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlrf_pkg::cfg_t                    cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_opcode,
  input  logic signed [dlrf_pkg::SMP_W-1:0] in_sample,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dlrf_pkg::SMP_W-1:0]        out_sample,
  output logic                              out_frame_end,
  output logic                              out_frame_discard,
  output logic                              out_last,
  output logic signed [dlrf_pkg::MA_W-1:0]  mul_a,
  output logic [dlrf_pkg::MB_W-1:0]         mul_b,
  input  logic signed [dlrf_pkg::P_W-1:0]   mul_p
);
  import dlrf_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FC_W  = $clog2(FRAME_SAMPLES + 1);
  localparam logic [CNT_W-1:0] MAX_CH   = CNT_W'(MAX_CHANNELS);
  localparam logic [FC_W-1:0]  FC_LAST  = FC_W'(FRAME_SAMPLES - 1);

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SMP_W-1:0]  prev_r, prev_nxt;
  logic signed [SMP_W-1:0]  mono_r, mono_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic [STEP_W-1:0]        cursor_r, cursor_nxt;
  logic [FC_W-1:0]          fc_r, fc_nxt;

  logic                     ovld_r, ovld_nxt;
  logic [SMP_W-1:0]         osmp_r, osmp_nxt;
  logic                     oend_r, oend_nxt;
  logic                     odisc_r, odisc_nxt;
  logic                     olast_r, olast_nxt;

  logic [CNT_W-1:0]         chans;
  logic [STEP_W-1:0]        step;
  logic                     out_free;
  logic                     accept;
  logic signed [SUM_W-1:0]  sum_add;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         num;
  logic [SMP_W:0]           quot;
  logic signed [SMP_W:0]    avg;
  logic signed [SMP_W:0]    diff;
  logic signed [P_W-1:0]    interp;
  logic [STEP_W-1:0]        cursor_adv;

  always_comb begin
    if (cfg.channel_count == '0) begin
      chans = CNT_W'(1);
    end else if (cfg.channel_count > MAX_CH) begin
      chans = MAX_CH;
    end else begin
      chans = cfg.channel_count;
    end
    if (cfg.rate_step < STEP_MIN) begin
      step = STEP_MIN;
    end else if (cfg.rate_step > STEP_MAX) begin
      step = STEP_MAX;
    end else begin
      step = cfg.rate_step;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign out_free   = ~ovld_r | out_tready;
  assign sum_add    = sum_r + SUM_W'(in_sample);
  assign mag        = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign num        = mag + SUM_W'(chans >> 1);
  assign quot       = mul_p[RCP_SHIFT +: SMP_W+1];
  assign avg        = sum_r[SUM_W-1] ? -$signed(quot) : $signed(quot);
  assign diff       = (SMP_W+1)'(mono_r) - (SMP_W+1)'(prev_r);
  assign interp     = $signed({{(P_W-SMP_W-FRAC_W){prev_r[SMP_W-1]}}, prev_r, {FRAC_W{1'b0}}})
                      + mul_p + P_W'(1 << (FRAC_W - 1));
  assign cursor_adv = cursor_r + step;

  // shared multiplier operands
  always_comb begin
    case (state_r)
      ST_INT_MUL, ST_INT_OUT: begin
        mul_a = MA_W'(diff);
        mul_b = cursor_r[FRAC_W-1:0];
      end
      default: begin
        mul_a = $signed({1'b0, num});
        mul_b = rcp(chans);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    mono_nxt      = mono_r;
    have_prev_nxt = have_prev_r;
    cursor_nxt    = cursor_r;
    fc_nxt        = fc_r;
    ovld_nxt      = ovld_r & ~out_tready;
    osmp_nxt      = osmp_r;
    oend_nxt      = oend_r;
    odisc_nxt     = odisc_r;
    olast_nxt     = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_RESTART) begin
            idx_nxt       = '0;
            sum_nxt       = '0;
            prev_nxt      = '0;
            have_prev_nxt = 1'b0;
            cursor_nxt    = '0;
            fc_nxt        = '0;
            if (fc_r != '0) begin
              state_nxt = ST_DISCARD;
            end
          end else begin
            sum_nxt = sum_add;
            if ((CNT_W'(idx_r) + CNT_W'(1)) < chans) begin
              idx_nxt = idx_r + IDX_W'(1);
            end else begin
              state_nxt = ST_AVG_MUL;
            end
          end
        end
      end
      ST_AVG_MUL: begin
        state_nxt = ST_AVG_DONE;
      end
      ST_AVG_DONE: begin
        sum_nxt = '0;
        idx_nxt = '0;
        if (!have_prev_r) begin
          prev_nxt      = avg[SMP_W-1:0];
          have_prev_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (cursor_r >= ONE_Q24) begin
          cursor_nxt = cursor_r - ONE_Q24;
          prev_nxt   = avg[SMP_W-1:0];
          state_nxt  = ST_IDLE;
        end else begin
          mono_nxt  = avg[SMP_W-1:0];
          state_nxt = ST_INT_MUL;
        end
      end
      ST_INT_MUL: begin
        state_nxt = ST_INT_OUT;
      end
      ST_INT_OUT: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          osmp_nxt  = interp[FRAC_W +: SMP_W];
          odisc_nxt = 1'b0;
          olast_nxt = (cursor_adv >= ONE_Q24);
          if (fc_r == FC_LAST) begin
            oend_nxt = 1'b1;
            fc_nxt   = '0;
          end else begin
            oend_nxt = 1'b0;
            fc_nxt   = fc_r + FC_W'(1);
          end
          if (cursor_adv >= ONE_Q24) begin
            cursor_nxt = cursor_adv - ONE_Q24;
            prev_nxt   = mono_r;
            state_nxt  = ST_IDLE;
          end else begin
            cursor_nxt = cursor_adv;
            state_nxt  = ST_INT_MUL;
          end
        end
      end
      ST_DISCARD: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          osmp_nxt  = '0;
          oend_nxt  = 1'b0;
          odisc_nxt = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      cursor_r    <= '0;
      fc_r        <= '0;
      ovld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      cursor_r    <= cursor_nxt;
      fc_r        <= fc_nxt;
      ovld_r      <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mono_r  <= mono_nxt;
    osmp_r  <= osmp_nxt;
    oend_r  <= oend_nxt;
    odisc_r <= odisc_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid        = ovld_r;
  assign out_sample        = osmp_r;
  assign out_frame_end     = oend_r;
  assign out_frame_discard = odisc_r;
  assign out_last          = olast_r;

endmodule

/* rtl/downmix_linear_resampler_framer_core.sv */
// ----------------------------------------------------------------------------
// downmix_linear_resampler_framer_core
// Interleaved PCM to mono downmix, linear-interpolation rate converter and
// framer with an APB-style configuration port.
// ----------------------------------------------------------------------------
// One channel sample is taken per input transaction. A sample that does not
// close a native frame leaves the sequencer in ST_IDLE. One that closes a
// native frame passes through ST_AVG_MUL and ST_AVG_DONE for the rounded
// average (a reciprocal multiply on the one shared multiplier), then through
// ST_INT_MUL and ST_INT_OUT per interpolated output on that same multiplier
// (n from 0 to 6 outputs), longer while out_tready low holds the output
// register. A restart passes through ST_DISCARD when a discard report is
// sent. The input is not ready while a sample is in work; a finished output
// waits in its own register while the next transaction is taken.
module downmix_linear_resampler_framer_core #(
  parameter int FRAME_SAMPLES = dlrf_pkg::FRAME_SAMPLES_DEF,
  parameter int MAX_CHANNELS  = dlrf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,    // [15:0] sample
  input  logic [0:0]                  in_tuser,    // [0] opcode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,   // [15:0] out_sample
  output logic [1:0]                  out_tuser,   // [0] frame_end, [1] frame_discard
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dlrf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [dlrf_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [dlrf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import dlrf_pkg::*;

  cfg_t                   cfg;
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]        mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic                   frame_end;
  logic                   frame_discard;

  dlrf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dlrf_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  dlrf_ctrl #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_opcode         (in_tuser[0]),
    .in_sample         ($signed(in_tdata)),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_sample        (out_tdata),
    .out_frame_end     (frame_end),
    .out_frame_discard (frame_discard),
    .out_last          (out_tlast),
    .mul_a             (mul_a),
    .mul_b             (mul_b),
    .mul_p             (mul_p)
  );

  assign out_tuser = {frame_discard, frame_end};

endmodule

/* rtl/dlrf_checker.sv */
// ----------------------------------------------------------------------------
// dlrf_checker
// Port-level assertions for the downmix / resampler / framer core.
// ----------------------------------------------------------------------------
module dlrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_pready
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // discard report is a lone silent final result
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 16'd0 && !out_tuser[0])
    else $error("bad discard report");

  // idle and empty right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

  // discard report after a restart frees the input once the output register is free
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0])
    ##1 (!in_tready && (!out_tvalid || out_tready)) |=> in_tready)
    else $error("restart report stalled the input");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("configuration port stalled");

endmodule

bind downmix_linear_resampler_framer_core dlrf_checker u_dlrf_checker (.*);
